FILE: hw/rtl/phv_pkg.sv
// ----------------------------------------------------------------------------
// phv_pkg
// Types, constants and saturating score helpers for the profile HMM
// Viterbi cell engine.
// ----------------------------------------------------------------------------
package phv_pkg;

   // score format: Q19.12 two's complement
   localparam int SCORE_W   = 32;
   localparam int LEN_CFG_W = 12;

   typedef logic signed [SCORE_W-1:0] score_type;

   localparam score_type SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam score_type SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   // minus infinity, round(-709.0895657 * 4096)
   localparam score_type NEG_INF   = -32'sd2904431;

   // item mode codes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_NEXT  = 2'd1;
   localparam logic [1:0] MODE_CELL  = 2'd2;

   // input item
   typedef struct packed {
      logic [1:0] mode;
      score_type  match_emission;
      score_type  insert_emission;
      score_type  trans_match_match;
      score_type  trans_match_insert;
      score_type  trans_match_delete;
      score_type  trans_insert_match;
      score_type  trans_insert_insert;
      score_type  trans_delete_match;
      score_type  trans_delete_delete;
   } req_type;

   // result item
   typedef struct packed {
      score_type match_score;
      score_type insert_score;
      score_type delete_score;
      logic      row_last;
   } rsp_type;

   // one state's transition set
   typedef struct packed {
      score_type mm;
      score_type mi;
      score_type md;
      score_type im;
      score_type ii;
      score_type dm;
      score_type dd;
   } trans_type;

   // one column entry: match, insert, delete scores
   typedef struct packed {
      score_type m_score;
      score_type i_score;
      score_type d_score;
   } col_type;

   function automatic trans_type to_trans(input req_type item);
      trans_type t;
      t.mm = item.trans_match_match;
      t.mi = item.trans_match_insert;
      t.md = item.trans_match_delete;
      t.im = item.trans_insert_match;
      t.ii = item.trans_insert_insert;
      t.dm = item.trans_delete_match;
      t.dd = item.trans_delete_delete;
      return t;
   endfunction

   function automatic score_type sat_add(input score_type a, input score_type b);
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end
      return s[SCORE_W-1:0];
   endfunction

   function automatic score_type sat_sub(input score_type a, input score_type b);
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} - {b[SCORE_W-1], b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end
      return s[SCORE_W-1:0];
   endfunction

   function automatic score_type score_max2(input score_type a, input score_type b);
      return (b > a) ? b : a;
   endfunction

endpackage

FILE: hw/rtl/phv_column_store.sv
// ----------------------------------------------------------------------------
// phv_column_store
// Previous-row column memory: one write port, one registered read port,
// with the same-cycle write forwarded to the read data.
// ----------------------------------------------------------------------------
module phv_column_store
   import phv_pkg::*;
#(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output col_type           rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  col_type           wr_data
);

   col_type mem [DEPTH];
   col_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, forwarding a write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/phv_cell_calc.sv
// ----------------------------------------------------------------------------
// phv_cell_calc
// Match / insert / delete recurrence for one cell, plus the new-row left
// neighbour carried to the next position.
// ----------------------------------------------------------------------------
module phv_cell_calc
   import phv_pkg::*;
(
   input  logic      first_row,
   input  logic      pos_zero,
   input  score_type match_emission,
   input  score_type insert_emission,
   input  trans_type prev_tr,
   input  trans_type cur_tr,
   input  col_type   old_col,
   input  col_type   old_left,
   input  score_type new_left_m,
   input  score_type new_left_i,
   output col_type   cell_out,
   output score_type next_left_m,
   output score_type next_left_i
);

   score_type best;
   score_type diff;

   always_comb begin
      best        = '0;
      diff        = '0;
      cell_out    = '0;
      next_left_m = '0;
      next_left_i = '0;
      if (first_row) begin
         // initialization row: match and delete stay at zero
         if (pos_zero) begin
            cell_out.i_score = NEG_INF;
            next_left_i      = '0;
         end else begin
            cell_out.i_score = score_max2(cur_tr.mi, sat_add(new_left_i, cur_tr.ii));
            next_left_i      = cell_out.i_score;
         end
      end else begin
         cell_out.d_score = score_max2(sat_add(old_col.m_score, prev_tr.md),
                                       sat_add(old_col.d_score, prev_tr.dd));
         if (pos_zero) begin
            cell_out.m_score = NEG_INF;
            cell_out.i_score = NEG_INF;
         end else begin
            // diagonal predecessor from the previous row
            best = score_max2(score_max2(sat_add(old_left.m_score, prev_tr.mm),
                                         sat_add(old_left.i_score, prev_tr.im)),
                              sat_add(old_left.d_score, prev_tr.dm));
            diff = sat_sub(match_emission, insert_emission);
            cell_out.m_score = sat_add(diff, best);
            cell_out.i_score = score_max2(sat_add(new_left_m, cur_tr.mi),
                                          sat_add(new_left_i, cur_tr.ii));
         end
         next_left_m = cell_out.m_score;
         next_left_i = cell_out.i_score;
      end
   end

endmodule

FILE: hw/rtl/profile_hmm_viterbi_cell.sv
// ----------------------------------------------------------------------------
// profile_hmm_viterbi_cell
// Profile HMM Viterbi row engine: match, insert and delete scores per cell.
// ----------------------------------------------------------------------------
// The block takes one item per clock and passes each cell item through a
// calc stage and the result register. In the cycle of acceptance the
// position counter picks the column entry and the column memory reads
// it; in the calc stage the recurrence runs on that entry and the left
// neighbours, writes the entry back and loads the result register. Input
// is held off only while that result register is full and not being
// taken. A start item empties the column stores at once through a fill
// count (entries at or above it read as zero), so no clearing pass runs
// after reset or between decodes. The csr port may be written only while
// no item is in flight.
module profile_hmm_viterbi_cell
   import phv_pkg::*;
#(
   parameter int MAX_POSITIONS = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_item,
   input  logic                 csr_write_enable,
   input  logic [LEN_CFG_W-1:0] csr_write_data
);

   localparam int POS_W  = $clog2(MAX_POSITIONS);
   localparam int FILL_W = $clog2(MAX_POSITIONS + 1);
   localparam int LEN_W  = (FILL_W > LEN_CFG_W) ? FILL_W : LEN_CFG_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_POSITIONS);
   localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

   // configuration
   logic [LEN_CFG_W-1:0] seq_len_ff, seq_len_in;

   // accept side
   logic [POS_W-1:0] pc_ff, pc_in;
   logic [LEN_W-1:0] seq_ext, len_eff, pc_ext, pos_ext, pos_inc;
   logic [POS_W-1:0] pos;
   logic             accept;
   logic             pos_last;

   // calc stage
   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_item_ff;
   logic [POS_W-1:0] s1_pos_ff;
   logic             s1_last_ff;
   logic             s1_pos_zero_ff;
   logic             s1_is_cell;
   logic             s1_adv;
   logic             out_free;

   // decode state
   trans_type        cur_tr_ff, cur_tr_in;
   trans_type        prev_tr_ff, prev_tr_in;
   logic             first_row_ff, first_row_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   col_type          old_left_ff, old_left_in;
   score_type        new_left_m_ff, new_left_m_in;
   score_type        new_left_i_ff, new_left_i_in;

   // column access and cell result
   col_type          rd_data;
   col_type          old_col;
   col_type          cell_res;
   score_type        next_left_m, next_left_i;
   logic [FILL_W-1:0] s1_pos_inc;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_item_ff;

   // effective row length and position of an arriving cell
   always_comb begin
      seq_ext = LEN_W'(seq_len_ff);
      if (seq_ext == '0) begin
         len_eff = ONE_LEN;
      end else if (seq_ext > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = seq_ext;
      end
      pc_ext   = LEN_W'(pc_ff);
      pos_ext  = (pc_ext >= len_eff) ? '0 : pc_ext;
      pos      = pos_ext[POS_W-1:0];
      pos_inc  = pos_ext + ONE_LEN;
      pos_last = (pos_inc == len_eff);
   end

   // handshake
   assign s1_is_cell = (s1_item_ff.mode == MODE_CELL);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && (!s1_is_cell || out_free);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign accept     = req_valid && req_ready;

   // configuration register and position counter
   always_comb begin
      seq_len_in = csr_write_enable ? csr_write_data : seq_len_ff;
      pc_in      = pc_ff;
      if (accept) begin
         if ((req_item.mode == MODE_START) || (req_item.mode == MODE_NEXT)) begin
            pc_in = '0;
         end else if (req_item.mode == MODE_CELL) begin
            pc_in = pos_last ? '0 : pos_inc[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= LEN_CFG_W'(2048);
         pc_ff      <= '0;
      end else begin
         seq_len_ff <= seq_len_in;
         pc_ff      <= pc_in;
      end
   end

   // calc stage valid and payload
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff     <= req_item;
         s1_pos_ff      <= pos;
         s1_last_ff     <= pos_last;
         s1_pos_zero_ff <= (pos_ext == '0);
      end
   end

   // column memory, read as an item is accepted into the calc stage
   phv_column_store #(
      .DEPTH  (MAX_POSITIONS),
      .ADDR_W (POS_W)
   ) u_column_store (
      .clock   (clock),
      .rd_en   (accept && (req_item.mode == MODE_CELL)),
      .rd_addr (pos),
      .rd_data (rd_data),
      .wr_en   (s1_adv && s1_is_cell),
      .wr_addr (s1_pos_ff),
      .wr_data (cell_res)
   );

   // entries not written since the last start read as zero
   assign old_col    = (FILL_W'(s1_pos_ff) < fill_ff) ? rd_data : '0;
   assign s1_pos_inc = FILL_W'(s1_pos_ff) + FILL_W'(1);

   phv_cell_calc u_cell_calc (
      .first_row       (first_row_ff),
      .pos_zero        (s1_pos_zero_ff),
      .match_emission  (s1_item_ff.match_emission),
      .insert_emission (s1_item_ff.insert_emission),
      .prev_tr         (prev_tr_ff),
      .cur_tr          (cur_tr_ff),
      .old_col         (old_col),
      .old_left        (old_left_ff),
      .new_left_m      (new_left_m_ff),
      .new_left_i      (new_left_i_ff),
      .cell_out        (cell_res),
      .next_left_m     (next_left_m),
      .next_left_i     (next_left_i)
   );

   // decode state update as items leave the calc stage
   always_comb begin
      cur_tr_in     = cur_tr_ff;
      prev_tr_in    = prev_tr_ff;
      first_row_in  = first_row_ff;
      fill_in       = fill_ff;
      old_left_in   = old_left_ff;
      new_left_m_in = new_left_m_ff;
      new_left_i_in = new_left_i_ff;
      if (s1_adv) begin
         case (s1_item_ff.mode)
            MODE_START: begin
               cur_tr_in     = to_trans(s1_item_ff);
               first_row_in  = 1'b1;
               fill_in       = '0;
               old_left_in   = '0;
               new_left_m_in = '0;
               new_left_i_in = '0;
            end
            MODE_NEXT: begin
               prev_tr_in    = cur_tr_ff;
               cur_tr_in     = to_trans(s1_item_ff);
               first_row_in  = 1'b0;
               old_left_in   = '0;
               new_left_m_in = '0;
               new_left_i_in = '0;
            end
            MODE_CELL: begin
               if (s1_pos_inc > fill_ff) begin
                  fill_in = s1_pos_inc;
               end
               if (!first_row_ff) begin
                  old_left_in = old_col;
               end
               new_left_m_in = next_left_m;
               new_left_i_in = next_left_i;
            end
            default: begin
               // unused mode: dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_tr_ff     <= '0;
         prev_tr_ff    <= '0;
         first_row_ff  <= 1'b1;
         fill_ff       <= '0;
         old_left_ff   <= '0;
         new_left_m_ff <= '0;
         new_left_i_ff <= '0;
      end else begin
         cur_tr_ff     <= cur_tr_in;
         prev_tr_ff    <= prev_tr_in;
         first_row_ff  <= first_row_in;
         fill_ff       <= fill_in;
         old_left_ff   <= old_left_in;
         new_left_m_ff <= new_left_m_in;
         new_left_i_ff <= new_left_i_in;
      end
   end

   // result register
   always_comb begin
      if (s1_adv && s1_is_cell) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_is_cell) begin
         rsp_item_ff.match_score  <= cell_res.m_score;
         rsp_item_ff.insert_score <= cell_res.i_score;
         rsp_item_ff.delete_score <= cell_res.d_score;
         rsp_item_ff.row_last     <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: hw/rtl/phv_checker.sv
// ----------------------------------------------------------------------------
// phv_checker
// Port-level checks for the Viterbi cell engine, bound to the top level.
// ----------------------------------------------------------------------------
module phv_checker
   import phv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_item
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // reset empties the result register
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input is only held off by a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked without a stalled result");

   // a fresh result comes from an accepted cell item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_item.mode == MODE_CELL), 2))
      else $error("result without a matching cell item");

endmodule

bind profile_hmm_viterbi_cell phv_checker u_phv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

FILE: tb/sv/profile_hmm_viterbi_cell_checker.sv
// ----------------------------------------------------------------------------
// profile_hmm_viterbi_cell_checker
// Watches the item, result and csr ports of the Viterbi cell engine, keeps
// its own copy of the column stores and transitions, predicts each cell's
// scores and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module profile_hmm_viterbi_cell_checker
   import phv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_item,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_item,
   input  logic                 csr_write_enable,
   input  logic [LEN_CFG_W-1:0] csr_write_data,
   output int                   fail_count,
   output int                   pending_count
);

   localparam int COLUMN_DEPTH = 2048;

   // predicted block state
   score_type            col_match [COLUMN_DEPTH];
   score_type            col_insert[COLUMN_DEPTH];
   score_type            col_delete[COLUMN_DEPTH];
   trans_type            cur_trans;
   trans_type            prev_trans;
   int                   cell_pos;
   bit                   on_first_row;
   score_type            above_left[3];
   score_type            row_left[2];
   logic [LEN_CFG_W-1:0] row_length;

   rsp_type expected_cells[$];
   int      mismatches;

   // saturate a wide sum to the score range
   function automatic score_type clamp_wide(input logic signed [SCORE_W+1:0] v);
      if (v > SCORE_MAX) return SCORE_MAX;
      if (v < SCORE_MIN) return SCORE_MIN;
      return v[SCORE_W-1:0];
   endfunction

   function automatic score_type add_sat(input score_type a, input score_type b);
      logic signed [SCORE_W+1:0] s;
      s = a;
      s = s + b;
      return clamp_wide(s);
   endfunction

   function automatic score_type sub_sat(input score_type a, input score_type b);
      logic signed [SCORE_W+1:0] s;
      s = a;
      s = s - b;
      return clamp_wide(s);
   endfunction

   function automatic score_type max_of(input score_type a, input score_type b);
      return (b > a) ? b : a;
   endfunction

   function automatic trans_type trans_of(input req_type it);
      trans_type t;
      t.mm = it.trans_match_match;
      t.mi = it.trans_match_insert;
      t.md = it.trans_match_delete;
      t.im = it.trans_insert_match;
      t.ii = it.trans_insert_insert;
      t.dm = it.trans_delete_match;
      t.dd = it.trans_delete_delete;
      return t;
   endfunction

   task automatic clear_columns();
      for (int k = 0; k < COLUMN_DEPTH; k++) begin
         col_match[k]  = '0;
         col_insert[k] = '0;
         col_delete[k] = '0;
      end
   endtask

   task automatic clear_lefts();
      above_left = '{default: '0};
      row_left   = '{default: '0};
   endtask

   task automatic reset_model();
      clear_columns();
      clear_lefts();
      cur_trans    = '0;
      prev_trans   = '0;
      cell_pos     = 0;
      on_first_row = 1'b1;
      row_length   = LEN_CFG_W'(COLUMN_DEPTH);
      expected_cells.delete();
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] cell mismatch: %s", $time, what);
   endtask

   task automatic compare_score(input string name, input score_type got,
                                input score_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // one cell of the recurrence, queues its expected scores
   task automatic predict_cell(input req_type it);
      int        len;
      int        pos;
      score_type m;
      score_type ins;
      score_type del;
      score_type om;
      score_type oi;
      score_type od;
      score_type best;
      rsp_type   cell_res;
      if (row_length == '0) len = 1;
      else if (int'(row_length) > COLUMN_DEPTH) len = COLUMN_DEPTH;
      else len = int'(row_length);
      pos = (cell_pos >= len) ? 0 : cell_pos;

      if (on_first_row) begin
         m   = '0;
         del = '0;
         if (pos == 0) begin
            ins         = NEG_INF;
            row_left[1] = '0;
         end else begin
            ins = max_of(add_sat('0, cur_trans.mi), add_sat(row_left[1], cur_trans.ii));
            row_left[1] = ins;
         end
         row_left[0] = '0;
      end else begin
         om  = col_match[pos];
         oi  = col_insert[pos];
         od  = col_delete[pos];
         del = max_of(add_sat(om, prev_trans.md), add_sat(od, prev_trans.dd));
         if (pos == 0) begin
            m   = NEG_INF;
            ins = NEG_INF;
         end else begin
            best = max_of(max_of(add_sat(above_left[0], prev_trans.mm),
                                 add_sat(above_left[1], prev_trans.im)),
                          add_sat(above_left[2], prev_trans.dm));
            m    = add_sat(sub_sat(it.match_emission, it.insert_emission), best);
            ins  = max_of(add_sat(row_left[0], cur_trans.mi),
                          add_sat(row_left[1], cur_trans.ii));
         end
         above_left = '{om, oi, od};
         row_left   = '{m, ins};
      end

      col_match[pos]  = m;
      col_insert[pos] = ins;
      col_delete[pos] = del;

      cell_res.match_score  = m;
      cell_res.insert_score = ins;
      cell_res.delete_score = del;
      cell_res.row_last     = (pos + 1 == len);
      expected_cells.push_back(cell_res);
      cell_pos = (pos + 1 >= len) ? 0 : pos + 1;
   endtask

   task automatic apply_item(input req_type it);
      case (it.mode)
         MODE_START: begin
            clear_columns();
            on_first_row = 1'b1;
            cur_trans    = trans_of(it);
            cell_pos     = 0;
            clear_lefts();
         end
         MODE_NEXT: begin
            prev_trans   = cur_trans;
            on_first_row = 1'b0;
            cur_trans    = trans_of(it);
            cell_pos     = 0;
            clear_lefts();
         end
         MODE_CELL: predict_cell(it);
         default: ;
      endcase
   endtask

   task automatic check_cell(input rsp_type got);
      rsp_type want;
      if (expected_cells.size() == 0) begin
         report_mismatch("result with no cell pending");
         return;
      end
      want = expected_cells.pop_front();
      compare_score("match_score", got.match_score, want.match_score);
      compare_score("insert_score", got.insert_score, want.insert_score);
      compare_score("delete_score", got.delete_score, want.delete_score);
      if (got.row_last !== want.row_last)
         report_mismatch($sformatf("row_last got %0b expected %0b",
                                   got.row_last, want.row_last));
   endtask

   // sample the ports at each edge
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_write_enable) row_length = csr_write_data;
         if (rsp_valid && rsp_ready) check_cell(rsp_item);
         if (req_valid && req_ready) apply_item(req_item);
      end
      fail_count    <= mismatches;
      pending_count <= expected_cells.size();
   end

endmodule

FILE: tb/sv/profile_hmm_viterbi_cell_tb.sv
// ----------------------------------------------------------------------------
// profile_hmm_viterbi_cell_tb
// Drives directed and random decodes into the Viterbi cell engine with
// bursty item traffic, a stalling result side and length changes between
// phases; the checker beside the block predicts and compares every cell.
// ----------------------------------------------------------------------------
module profile_hmm_viterbi_cell_tb;
   import phv_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum int {RX_OPEN, RX_COIN, RX_RARE, RX_THIRD} rx_style_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_write_enable = 1'b0;
   logic [LEN_CFG_W-1:0] csr_write_data = '0;

   int fail_count;
   int pending_count;
   int sent_items;
   int burst_left;
   bit hold_wanted;

   profile_hmm_viterbi_cell u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   profile_hmm_viterbi_cell_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly small log-odds scores, with extremes and raw words mixed in
   function automatic score_type rand_score();
      int v;
      case ($urandom_range(0, 15))
         0: return SCORE_MAX;
         1: return SCORE_MIN;
         2: return NEG_INF;
         3: return '0;
         4, 5, 6: return score_type'($urandom);
         default: begin
            v = $urandom_range(0, 40960);
            return score_type'(v - 32768);
         end
      endcase
   endfunction

   function automatic req_type rand_item(input logic [1:0] mode);
      req_type it;
      it.mode                = mode;
      it.match_emission      = rand_score();
      it.insert_emission     = rand_score();
      it.trans_match_match   = rand_score();
      it.trans_match_insert  = rand_score();
      it.trans_match_delete  = rand_score();
      it.trans_insert_match  = rand_score();
      it.trans_insert_insert = rand_score();
      it.trans_delete_match  = rand_score();
      it.trans_delete_delete = rand_score();
      return it;
   endfunction

   function automatic req_type cell_with(input score_type me, input score_type ie);
      req_type it;
      it                 = rand_item(MODE_CELL);
      it.match_emission  = me;
      it.insert_emission = ie;
      return it;
   endfunction

   function automatic req_type load_all(input logic [1:0] mode, input score_type v);
      req_type it;
      it                     = rand_item(mode);
      it.trans_match_match   = v;
      it.trans_match_insert  = v;
      it.trans_match_delete  = v;
      it.trans_insert_match  = v;
      it.trans_insert_insert = v;
      it.trans_delete_match  = v;
      it.trans_delete_delete = v;
      return it;
   endfunction

   // offer one item, in bursts separated by random gaps
   task automatic send(input req_type it);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (it.mode != MODE_UNUSED) sent_items++;
   endtask

   // stop offering and wait until every cell has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_CFG_W-1:0] v);
      drain();
      csr_write_data   <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // one random length, then rows of cells with some broken rows and noise
   task automatic run_phase(input bit want_hold);
      logic [LEN_CFG_W-1:0] len_value;
      int                   eff_len;
      int                   phase_end;
      int                   cells;
      case ($urandom_range(0, 9))
         0: len_value = '0;
         1: len_value = LEN_CFG_W'(1);
         2, 3, 4, 5: len_value = LEN_CFG_W'($urandom_range(2, 8));
         6, 7: len_value = LEN_CFG_W'($urandom_range(9, 40));
         default: len_value = LEN_CFG_W'($urandom_range(41, 90));
      endcase
      write_length(len_value);
      if (want_hold) hold_wanted = 1'b1;
      eff_len   = (len_value == '0) ? 1 : int'(len_value);
      phase_end = sent_items + $urandom_range(60, 180);
      if ($urandom_range(0, 2) != 0) send(rand_item(MODE_START));
      while (sent_items < phase_end) begin
         case ($urandom_range(0, 7))
            0: cells = eff_len + $urandom_range(1, 3);
            1: cells = $urandom_range(0, eff_len - 1);
            default: cells = eff_len;
         endcase
         repeat (cells) begin
            if ($urandom_range(0, 24) == 0) send(rand_item(MODE_UNUSED));
            send(rand_item(MODE_CELL));
         end
         send(rand_item(($urandom_range(0, 11) == 0) ? MODE_START : MODE_NEXT));
      end
   endtask

   // result side: changing stall styles plus one long hold-off
   initial begin
      rx_style_type style;
      int           span;
      int           hold_left;
      int           tick;
      bit           hold_done;
      style     = RX_OPEN;
      span      = 0;
      hold_left = 0;
      tick      = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (span == 0) begin
               style = rx_style_type'($urandom_range(0, 3));
               span  = $urandom_range(50, 300);
            end
            span--;
            case (style)
               RX_OPEN:  rsp_ready <= 1'b1;
               RX_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
               RX_RARE:  rsp_ready <= ($urandom_range(0, 7) != 0);
               default:  rsp_ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int random_start;
      int phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first row straight out of reset, default length
      send(cell_with(SCORE_MAX, SCORE_MIN));
      send(cell_with(SCORE_MIN, SCORE_MAX));
      send(cell_with('0, '0));

      // saturating transitions on the first and a later row
      write_length(LEN_CFG_W'(4));
      send(load_all(MODE_START, SCORE_MAX));
      repeat (4) send(rand_item(MODE_CELL));
      send(load_all(MODE_NEXT, SCORE_MIN));
      send(cell_with(SCORE_MAX, SCORE_MIN));
      send(cell_with(SCORE_MIN, SCORE_MAX));
      send(cell_with(NEG_INF, '0));
      send(cell_with(SCORE_MAX, SCORE_MAX));
      send(rand_item(MODE_UNUSED));

      // next state in mid-row, then a counter left beyond a shorter row
      send(load_all(MODE_NEXT, NEG_INF));
      repeat (2) send(rand_item(MODE_CELL));
      send(load_all(MODE_NEXT, '0));
      repeat (3) send(rand_item(MODE_CELL));
      write_length(LEN_CFG_W'(2));
      repeat (2) send(rand_item(MODE_CELL));
      write_length('0);
      repeat (2) send(rand_item(MODE_CELL));

      // an over-range length clamps to the full depth
      write_length('1);
      send(rand_item(MODE_START));
      repeat (3) send(rand_item(MODE_CELL));
      send(rand_item(MODE_NEXT));
      repeat (6) send(rand_item(MODE_CELL));

      random_start = sent_items;
      phase        = 0;
      while (sent_items < random_start + 1550) begin
         run_phase(phase == 1);
         phase++;
      end

      write_length(LEN_CFG_W'(2048));
      send(rand_item(MODE_START));
      repeat (5) send(rand_item(MODE_CELL));
      drain();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #8000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
